>>> rtl/core/ofi_return_lagged_covariance_assert.svh
// Assertion macros for the lagged covariance block.
// Used by the top-level RTL file in this folder; expects clk and rst in scope.
`ifndef OFI_RETURN_LAGGED_COVARIANCE_ASSERT_SVH
`define OFI_RETURN_LAGGED_COVARIANCE_ASSERT_SVH

// ante implies cons in the same cycle
`define ORLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("orlc: implication check failed");

// cond never holds
`define ORLC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("orlc: forbidden condition seen");

`endif

>>> rtl/core/orlc_pkg.sv
// Shared widths, constants and types for the lagged covariance block.
// No dependencies.
`default_nettype none
package orlc_pkg;

  localparam int QTY_W   = 24;
  localparam int IMB_W   = 26;
  localparam int RET_W   = 25;
  localparam int PROD_W  = IMB_W + RET_W;
  localparam int LAG_W   = 4;
  localparam int COV_W   = 60;
  localparam int WIN_W   = 13;
  localparam int NUM_W   = 128;
  localparam int Q8_SHIFT = 8;
  localparam int MIN_SAMPLES = 3;

  localparam int DEF_HISTORY_DEPTH = 4096;
  localparam int DEF_MAX_LAGS      = 8;

  localparam logic [LAG_W-1:0] RST_MAX_LAG    = 4'd5;
  localparam logic [WIN_W-1:0] RST_WINDOW_LEN = 13'd200;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b1;

  localparam int N_TERMS = 4;
  // terms subtracted from the numerator
  localparam logic [N_TERMS-1:0] TERM_NEG = 4'b0110;

  localparam logic [63:0] SAT_POS = 64'h07FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_NEG = 64'h0800_0000_0000_0000;

  typedef struct packed {
    logic                    feed;
    logic                    ov;
    logic signed [IMB_W-1:0] o;
    logic signed [RET_W-1:0] r;
  } link_t;

endpackage
`default_nettype wire

>>> rtl/core/orlc_cell.sv
// One lag cell: delays imbalance by one sample and accumulates lagged sums.
// Depends on orlc_pkg.
`default_nettype none
module orlc_cell #(
  parameter int MW = 13
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            clear,
  input  wire orlc_pkg::link_t link_in,
  output orlc_pkg::link_t      link_out,
  output logic signed [orlc_pkg::PROD_W+MW-1:0] p_sum,
  output logic signed [orlc_pkg::IMB_W+MW-1:0]  sop_sum,
  output logic signed [orlc_pkg::RET_W+MW-1:0]  srp_sum
);
  import orlc_pkg::*;

  localparam int PW  = PROD_W + MW;
  localparam int SOW = IMB_W + MW;
  localparam int SRW = RET_W + MW;

  logic                     d_v;
  logic signed [IMB_W-1:0]  d_o;
  logic                     pv;
  logic signed [PROD_W-1:0] prod;
  logic signed [IMB_W-1:0]  po;
  logic signed [RET_W-1:0]  pr;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      d_v <= 1'b0;
      pv  <= 1'b0;
    end else begin
      if (link_in.feed) begin
        d_v <= link_in.ov;
      end
      pv <= link_in.feed && d_v;
    end
    if (link_in.feed) begin
      d_o <= link_in.o;
    end
    prod <= d_o * link_in.r;
    po   <= d_o;
    pr   <= link_in.r;
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      p_sum   <= '0;
      sop_sum <= '0;
      srp_sum <= '0;
    end else if (pv) begin
      p_sum   <= p_sum + PW'(prod);
      sop_sum <= sop_sum + SOW'(po);
      srp_sum <= srp_sum + SRW'(pr);
    end
  end

  assign link_out.feed = link_in.feed;
  assign link_out.ov   = d_v;
  assign link_out.o    = d_o;
  assign link_out.r    = link_in.r;

endmodule
`default_nettype wire

>>> rtl/core/orlc_arith.sv
// Serial numerator build (shift-add) and restoring divider with Q8 rounding.
// Depends on orlc_pkg.
`default_nettype none
module orlc_arith #(
  parameter int PW = 64,
  parameter int DW = 39
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [orlc_pkg::NUM_W-1:0] a_op [orlc_pkg::N_TERMS],
  input  wire logic signed [PW-1:0]          b_op [orlc_pkg::N_TERMS],
  input  wire logic [DW-1:0]                 den,
  output logic                               done,
  output logic [orlc_pkg::COV_W-1:0]         cov
);
  import orlc_pkg::*;

  localparam int BCW = $clog2(PW);
  localparam int DCW = $clog2(NUM_W);

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_LOAD = 7'b0000010,
    A_MUL  = 7'b0000100,
    A_ABS  = 7'b0001000,
    A_RND  = 7'b0010000,
    A_DIV  = 7'b0100000,
    A_SAT  = 7'b1000000
  } astate_t;

  astate_t                  state;
  logic [1:0]               term;
  logic [BCW-1:0]           bitc;
  logic [DCW-1:0]           divc;
  logic signed [NUM_W-1:0]  a;
  logic signed [PW-1:0]     b;
  logic signed [NUM_W-1:0]  acc;
  logic [NUM_W-1:0]         mag;
  logic                     neg;
  logic [DW-1:0]            rem;
  logic [63:0]              q;
  logic                     qhi;
  logic                     sub;
  logic [DW:0]              rem_sh;
  logic [63:0]              qmag;

  assign sub    = TERM_NEG[term] ^ (bitc == BCW'(PW - 1));
  assign rem_sh = {rem, mag[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      unique case (state)
        A_IDLE: begin
          if (start) begin
            state <= A_LOAD;
          end
          term <= '0;
          acc  <= '0;
        end
        A_LOAD: begin
          a     <= a_op[term];
          b     <= b_op[term];
          bitc  <= '0;
          state <= A_MUL;
        end
        A_MUL: begin
          if (b[0]) begin
            acc <= sub ? acc - a : acc + a;
          end
          a    <= a <<< 1;
          b    <= b >>> 1;
          bitc <= bitc + 1'b1;
          if (bitc == BCW'(PW - 1)) begin
            if (term == 2'(N_TERMS - 1)) begin
              state <= A_ABS;
            end else begin
              term  <= term + 1'b1;
              state <= A_LOAD;
            end
          end
        end
        A_ABS: begin
          neg   <= acc[NUM_W-1];
          mag   <= (acc[NUM_W-1] ? NUM_W'(-acc) : NUM_W'(acc)) << Q8_SHIFT;
          state <= A_RND;
        end
        A_RND: begin
          mag   <= mag + NUM_W'(den >> 1);
          rem   <= '0;
          q     <= '0;
          qhi   <= 1'b0;
          divc  <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= DW'(rem_sh - {1'b0, den});
            q   <= {q[62:0], 1'b1};
          end else begin
            rem <= DW'(rem_sh);
            q   <= {q[62:0], 1'b0};
          end
          qhi  <= qhi | q[63];
          mag  <= mag << 1;
          divc <= divc + 1'b1;
          if (divc == DCW'(NUM_W - 1)) begin
            state <= A_SAT;
          end
        end
        A_SAT: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (neg) begin
      qmag = (qhi || q > SAT_NEG) ? SAT_NEG : q;
      cov  = COV_W'(64'd0 - qmag);
    end else begin
      qmag = (qhi || q > SAT_POS) ? SAT_POS : q;
      cov  = COV_W'(qmag);
    end
  end

  assign done = (state == A_SAT);

endmodule
`default_nettype wire

>>> rtl/core/ofi_return_lagged_covariance.sv
// Lagged return / order-flow-imbalance covariance, top level.
// Depends on orlc_pkg, orlc_cell, orlc_arith and the assertion macro header.
//
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser, one per market
// depth update. Results leave on m_tvalid/m_tready/m_tdata/m_tlast, one item
// per lag 1..min(max_lag, MAX_LAGS); m_tlast marks the highest lag. An item
// with fewer than three samples in its window, or max_lag zero, gives none.
// s_tready is high only while the block is idle; one update is handled at
// a time. After acceptance the history RAM is swept once over the window
// (one sample per cycle through the chain of lag cells), then each lag goes
// through the shared serial arithmetic unit: four shift-add passes and a
// 128-step divider. A lag with no pairs skips the arithmetic and gives a
// zero covariance. The last result sits in the output register while the
// next update is accepted; a stalled receiver holds the sequencer before it
// loads the next result. Reset (rst, synchronous) empties the history,
// zeroes the previous depth and restores max_lag = 5 and window_len = 200.
// The history RAM needs no clearing pass.
`default_nettype none
`include "ofi_return_lagged_covariance_assert.svh"
module ofi_return_lagged_covariance #(
  parameter int HISTORY_DEPTH = orlc_pkg::DEF_HISTORY_DEPTH,
  parameter int MAX_LAGS      = orlc_pkg::DEF_MAX_LAGS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [orlc_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [orlc_pkg::WIN_W-1:0]        cfg_wdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // bid_near_qty, ask_near_qty, close_ticks, prior_close_ticks
  input  wire logic [95:0]                       s_tdata,
  // first_update, has_prior_bar
  input  wire logic [1:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // lag, covariance_q8
  output logic [63:0]                            m_tdata,
  output logic                                   m_tlast
);
  import orlc_pkg::*;

  localparam int AW  = $clog2(HISTORY_DEPTH);
  localparam int MW  = $clog2(HISTORY_DEPTH + 1);
  localparam int PW  = PROD_W + MW;
  localparam int SOW = IMB_W + MW;
  localparam int SRW = RET_W + MW;
  localparam int DW  = 3 * MW;
  localparam int LIW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SETUP = 8'b00000010,
    ST_SWEEP = 8'b00000100,
    ST_DRAIN = 8'b00001000,
    ST_LAG   = 8'b00010000,
    ST_PREP  = 8'b00100000,
    ST_CALC  = 8'b01000000,
    ST_OUT   = 8'b10000000
  } state_t;

  state_t state;

  logic [LAG_W-1:0] max_lag;
  logic [WIN_W-1:0] window_len;

  logic signed [IMB_W-1:0] imb_mem [HISTORY_DEPTH];
  logic signed [RET_W-1:0] ret_mem [HISTORY_DEPTH];

  logic [AW-1:0]    wp;
  logic [MW-1:0]    count;
  logic [QTY_W-1:0] prev_bid;
  logic [QTY_W-1:0] prev_ask;

  logic [MW-1:0]    m_reg;
  logic [MW-1:0]    m_next;
  logic [AW-1:0]    base_next;
  logic [LAG_W-1:0] lags_reg;
  logic [LAG_W-1:0] lags_next;
  logic [2*MW-1:0]  mm;
  logic [AW-1:0]    rd_addr;
  logic [MW-1:0]    rd_cnt;
  logic             rd_v;
  logic signed [IMB_W-1:0] o_q;
  logic signed [RET_W-1:0] r_q;
  logic [1:0]       drain_cnt;
  logic             clear;

  logic signed [SRW-1:0] s_r;
  logic signed [SOW-1:0] s_o;
  logic signed [MW+SRW:0] msr;
  logic signed [MW+SOW:0] mso;
  logic signed [MW+SRW:0] csr;

  logic [LAG_W-1:0] lag_reg;
  logic [MW-1:0]    cnt_reg;
  logic [DW-1:0]    den;
  logic signed [PW-1:0]  sel_p;
  logic signed [SOW-1:0] sel_sop;
  logic signed [SRW-1:0] sel_srp;
  logic [COV_W-1:0] cov_reg;
  logic             arith_start;
  logic             arith_done;
  logic [COV_W-1:0] arith_cov;

  logic [QTY_W-1:0] in_bid;
  logic [QTY_W-1:0] in_ask;
  logic [QTY_W-1:0] in_close;
  logic [QTY_W-1:0] in_prior;
  logic             in_first;
  logic             in_has_prior;
  logic signed [IMB_W-1:0] imb;
  logic signed [RET_W-1:0] ret;
  logic [QTY_W-1:0] pb;
  logic [QTY_W-1:0] pa;
  logic             accept;
  logic             out_load;

  link_t link [MAX_LAGS+1];
  logic signed [PW-1:0]  cell_p   [MAX_LAGS];
  logic signed [SOW-1:0] cell_sop [MAX_LAGS];
  logic signed [SRW-1:0] cell_srp [MAX_LAGS];

  logic signed [NUM_W-1:0] a_op [N_TERMS];
  logic signed [PW-1:0]    b_op [N_TERMS];

  assign in_bid       = s_tdata[23:0];
  assign in_ask       = s_tdata[47:24];
  assign in_close     = s_tdata[71:48];
  assign in_prior     = s_tdata[95:72];
  assign in_first     = s_tuser[0];
  assign in_has_prior = s_tuser[1];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign clear    = (state == ST_SETUP);

  always_comb begin
    pb  = in_first ? in_bid : prev_bid;
    pa  = in_first ? in_ask : prev_ask;
    imb = ($signed({2'b00, in_bid}) - $signed({2'b00, pb}))
        - ($signed({2'b00, in_ask}) - $signed({2'b00, pa}));
    ret = in_has_prior ? ($signed({1'b0, in_close}) - $signed({1'b0, in_prior}))
                       : '0;
  end

  always_comb begin
    int t;
    if (int'(count) < int'(window_len)) begin
      m_next = count;
    end else begin
      m_next = MW'(window_len);
    end
    t = int'(wp) + HISTORY_DEPTH - int'(m_next);
    if (t >= HISTORY_DEPTH) begin
      t = t - HISTORY_DEPTH;
    end
    base_next = AW'(t);
    if (int'(max_lag) > MAX_LAGS) begin
      lags_next = LAG_W'(MAX_LAGS);
    end else begin
      lags_next = max_lag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lag    <= RST_MAX_LAG;
      window_len <= RST_WINDOW_LEN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_LAG:    max_lag    <= cfg_wdata[LAG_W-1:0];
        CFG_WINDOW_LEN: window_len <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      imb_mem[wp] <= imb;
      ret_mem[wp] <= ret;
    end
    if (state == ST_SWEEP) begin
      o_q <= imb_mem[rd_addr];
      r_q <= ret_mem[rd_addr];
    end
  end

  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      wp          <= '0;
      count       <= '0;
      prev_bid    <= '0;
      prev_ask    <= '0;
      rd_v        <= 1'b0;
      arith_start <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      rd_v        <= (state == ST_SWEEP);
      arith_start <= (state == ST_PREP);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_bid <= in_bid;
            prev_ask <= in_ask;
            wp <= (wp == AW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
            if (int'(count) < HISTORY_DEPTH) begin
              count <= count + 1'b1;
            end
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          m_reg    <= m_next;
          lags_reg <= lags_next;
          rd_addr  <= base_next;
          rd_cnt   <= '0;
          mm       <= m_next * m_next;
          if (int'(m_next) < MIN_SAMPLES || lags_next == '0) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          rd_addr <= (rd_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : rd_addr + 1'b1;
          rd_cnt  <= rd_cnt + 1'b1;
          if (rd_cnt == m_reg - 1'b1) begin
            drain_cnt <= '0;
            state     <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          drain_cnt <= drain_cnt + 1'b1;
          if (drain_cnt == DRAIN_LAST) begin
            msr     <= $signed({1'b0, m_reg}) * s_r;
            mso     <= $signed({1'b0, m_reg}) * s_o;
            lag_reg <= LAG_W'(1);
            state   <= ST_LAG;
          end
        end
        ST_LAG: begin
          sel_p   <= cell_p[LIW'(lag_reg - 1'b1)];
          sel_sop <= cell_sop[LIW'(lag_reg - 1'b1)];
          sel_srp <= cell_srp[LIW'(lag_reg - 1'b1)];
          cnt_reg <= m_reg - MW'(lag_reg);
          if (int'(lag_reg) >= int'(m_reg)) begin
            cov_reg <= '0;
            state   <= ST_OUT;
          end else begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          csr   <= $signed({1'b0, cnt_reg}) * s_r;
          den   <= cnt_reg * mm;
          state <= ST_CALC;
        end
        ST_CALC: begin
          if (arith_done) begin
            cov_reg <= arith_cov;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (lag_reg == lags_reg) begin
              state <= ST_IDLE;
            end else begin
              lag_reg <= lag_reg + 1'b1;
              state   <= ST_LAG;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {cov_reg, lag_reg};
      m_tlast <= (lag_reg == lags_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      s_r <= '0;
      s_o <= '0;
    end else if (rd_v) begin
      s_r <= s_r + SRW'(r_q);
      s_o <= s_o + SOW'(o_q);
    end
  end

  assign link[0].feed = rd_v;
  assign link[0].ov   = 1'b1;
  assign link[0].o    = o_q;
  assign link[0].r    = r_q;

  for (genvar k = 0; k < MAX_LAGS; k++) begin : g_cell
    orlc_cell #(.MW(MW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (clear),
      .link_in  (link[k]),
      .link_out (link[k+1]),
      .p_sum    (cell_p[k]),
      .sop_sum  (cell_sop[k]),
      .srp_sum  (cell_srp[k])
    );
  end

  assign a_op[0] = NUM_W'($signed({1'b0, mm}));
  assign a_op[1] = NUM_W'(msr);
  assign a_op[2] = NUM_W'(mso);
  assign a_op[3] = NUM_W'(csr);
  assign b_op[0] = sel_p;
  assign b_op[1] = PW'(sel_sop);
  assign b_op[2] = PW'(sel_srp);
  assign b_op[3] = PW'(s_o);

  orlc_arith #(.PW(PW), .DW(DW)) u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (arith_start),
    .a_op  (a_op),
    .b_op  (b_op),
    .den   (den),
    .done  (arith_done),
    .cov   (arith_cov)
  );

  `ORLC_ASSERT_IMP(a_sweep_in_window, state == ST_SWEEP, rd_cnt < m_reg)
  `ORLC_ASSERT_IMP(a_done_in_calc, arith_done, state == ST_CALC)
  `ORLC_ASSERT_NEVER(a_pending_mid_item, m_tvalid && !m_tlast && state == ST_IDLE)

endmodule
`default_nettype wire

>>> sim/ofi_return_lagged_covariance_tb.sv
// Self-checking testbench for ofi_return_lagged_covariance: directed table, then random
// market-depth updates over several lag/window settings, checked against an in-bench model.
// Depends on orlc_pkg and the block's RTL.
`default_nettype none
module ofi_return_lagged_covariance_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import orlc_pkg::*;

  localparam int DEPTH      = 4096;
  localparam int LAGS       = 8;
  localparam int CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic [3:0]  lag;
    logic [59:0] cov;
    logic        last;
  } cov_item_t;

  typedef struct {
    logic [1:0]  user;
    logic [23:0] bid, ask, cls, prior;
    bit          none;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [WIN_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0, s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0, m_tlast;
  logic [63:0] m_tdata;

  ofi_return_lagged_covariance i_dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_wdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  always #1 clk = ~clk;

  // model state
  logic signed [25:0] imb_hist [DEPTH];
  logic signed [24:0] ret_hist [DEPTH];
  int unsigned n_samples, wr_ptr;
  logic [23:0] last_bid, last_ask;
  logic [3:0]  lag_reg;
  logic [12:0] win_reg;

  cov_item_t cov_queue[$];
  int errors = 0;
  int items_sent = 0, results_seen = 0;
  longint cycles = 0;

  function automatic logic [59:0] q8_divide(logic signed [127:0] num, logic [63:0] den);
    logic [127:0] mag, q;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = (mag << Q8_SHIFT) + (den >> 1);
    q = mag / den;
    if (neg) begin
      if (q > SAT_NEG) q = SAT_NEG;
      return 60'(-q);
    end
    if (q > SAT_POS) q = SAT_POS;
    return 60'(q);
  endfunction

  task automatic predict_covariances(input logic [1:0] user, input logic [95:0] data);
    logic [23:0] bid, ask;
    longint imb, ret, s_r, s_o, pr, sop, srp, mm;
    int unsigned m, base, lags, cnt;
    logic signed [127:0] num, t;
    cov_item_t it;
    bid = data[23:0];
    ask = data[47:24];
    if (user[0]) begin
      last_bid = bid;
      last_ask = ask;
    end
    imb = (longint'(bid) - longint'(last_bid)) - (longint'(ask) - longint'(last_ask));
    last_bid = bid;
    last_ask = ask;
    ret = user[1] ? longint'(data[71:48]) - longint'(data[95:72]) : 0;
    imb_hist[wr_ptr] = imb[25:0];
    ret_hist[wr_ptr] = ret[24:0];
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (n_samples < DEPTH) n_samples++;
    m = n_samples < win_reg ? n_samples : win_reg;
    if (m < MIN_SAMPLES) return;
    base = (wr_ptr + DEPTH - m) % DEPTH;
    s_r = 0;
    s_o = 0;
    for (int i = 0; i < m; i++) begin
      s_r += ret_hist[(base + i) % DEPTH];
      s_o += imb_hist[(base + i) % DEPTH];
    end
    mm = longint'(m) * m;
    lags = lag_reg > LAGS ? LAGS : lag_reg;
    for (int lag = 1; lag <= lags; lag++) begin
      it.lag = 4'(lag);
      it.last = (lag == lags);
      it.cov = '0;
      if (lag < m) begin
        cnt = m - lag;
        pr = 0;
        sop = 0;
        srp = 0;
        for (int i = 0; i < cnt; i++) begin
          pr  += longint'(ret_hist[(base + i + lag) % DEPTH]) * imb_hist[(base + i) % DEPTH];
          sop += imb_hist[(base + i) % DEPTH];
          srp += ret_hist[(base + i + lag) % DEPTH];
        end
        num = mm;
        num = num * pr;
        t = longint'(m) * s_r;
        num = num - t * sop;
        t = longint'(m) * s_o;
        num = num - t * srp;
        t = longint'(cnt) * s_r;
        num = num + t * s_o;
        it.cov = q8_divide(num, 64'(cnt) * 64'(mm));
      end
      cov_queue.push_back(it);
    end
  endtask

  // receiver: stalls in random bursts, with calm stretches
  int stall_left = 0;
  bit calm = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 3000 == 0) calm <= $urandom_range(0, 2) == 0;
    if (stall_left > 0) begin
      m_tready <= 0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1;
      if (!calm && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 40);
    end
  end

  always @(posedge clk) begin
    cov_item_t e;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (cov_queue.size() == 0) begin
        $error("unexpected result lag=%0d cov=%h", m_tdata[3:0], m_tdata[63:4]);
        errors++;
      end else begin
        e = cov_queue.pop_front();
        if (m_tdata[3:0] !== e.lag) begin
          $error("lag: expected %0d, got %0d", e.lag, m_tdata[3:0]);
          errors++;
        end
        if (m_tdata[63:4] !== e.cov) begin
          $error("covariance_q8: expected %h, got %h", e.cov, m_tdata[63:4]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last_lag: expected %0d, got %0d", e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_update(input logic [1:0] user, input logic [95:0] data);
    int gap;
    s_tvalid <= 1;
    s_tuser <= user;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_covariances(user, data);
    items_sent++;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (cov_queue.size() != 0 || !s_tready) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_MAX_LAG) lag_reg = val[3:0];
    else win_reg = val;
  endtask

  function automatic logic [23:0] near(logic [23:0] v);
    int d;
    if ($urandom_range(0, 3) == 0) return 24'($urandom);
    d = $urandom_range(0, 200) - 100;
    return 24'(int'(v) + d);
  endfunction

  stim_row_t rows[$];
  int unsigned lag_set[9]  = '{8, 15, 0, 1, 8, 3, 8, 6, 2};
  int unsigned win_set[9]  = '{3, 4, 10, 1, 0, 4096, 16, 50, 7};
  int unsigned phase_len[9] = '{60, 50, 25, 25, 25, 30, 110, 90, 60};

  initial begin
    logic [1:0] u;
    logic [23:0] b, a, c, p;
    int n_before;
    n_samples = 0;
    wr_ptr = 0;
    last_bid = 0;
    last_ask = 0;
    lag_reg = RST_MAX_LAG;
    win_reg = RST_WINDOW_LEN;

    // no first update: previous depth starts at zero
    rows.push_back('{2'b00, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 1});
    rows.push_back('{2'b11, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1});
    rows.push_back('{2'b10, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 0});
    rows.push_back('{2'b10, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 0});
    rows.push_back('{2'b00, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 0});
    rows.push_back('{2'b01, 24'h123456, 24'h654321, 24'hAAAAAA, 24'h555555, 0});
    rows.push_back('{2'b10, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 0});
    rows.push_back('{2'b11, 24'h000001, 24'hFFFFFE, 24'h800000, 24'h7FFFFF, 0});
    rows.push_back('{2'b10, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 0});
    rows.push_back('{2'b10, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 0});
    rows.push_back('{2'b00, 24'h000100, 24'h000100, 24'h000010, 24'h000020, 0});
    rows.push_back('{2'b10, 24'h0F0F0F, 24'hF0F0F0, 24'h0F0F0F, 24'hF0F0F0, 0});

    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[k]) begin
      n_before = cov_queue.size();
      send_update(rows[k].user, {rows[k].prior, rows[k].cls, rows[k].ask, rows[k].bid});
      if (rows[k].none && cov_queue.size() != n_before) begin
        $error("row %0d: model expects results where none are due", k);
        errors++;
      end
    end

    b = 24'h100000;
    a = 24'h100000;
    c = 24'h400000;
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      write_reg(CFG_MAX_LAG, 13'(lag_set[ph]));
      write_reg(CFG_WINDOW_LEN, 13'(win_set[ph]));
      for (int n = 0; n < phase_len[ph]; n++) begin
        u[0] = $urandom_range(0, 7) == 0;
        u[1] = $urandom_range(0, 3) != 0;
        b = near(b);
        a = near(a);
        p = c;
        c = near(c);
        if ($urandom_range(0, 9) == 0) p = 24'($urandom);
        send_update(u, {p, c, a, b});
      end
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (cov_queue.size() != 0) begin
      $error("%0d expected results never arrived", cov_queue.size());
      errors++;
    end
    $display("covered %0d updates and %0d lag results over 10 lag/window settings",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
